### rtl/gthq_pkg.sv
// Package for the grid terrain height query block.
// Holds operation codes, register indexes, sizes and the divider request and response types.
package gthq_pkg;

	localparam int MAX_DIVISIONS = 64;
	localparam int VERTEX_COUNT  = (MAX_DIVISIONS + 1) * (MAX_DIVISIONS + 1);
	localparam int VIDX_W        = $clog2(VERTEX_COUNT);
	localparam int DIVS_W        = $clog2(MAX_DIVISIONS + 1);

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_RAISE = 2'd2;

	localparam logic [1:0] REG_DIVISIONS = 2'd0;
	localparam logic [1:0] REG_EXTENT_X  = 2'd1;
	localparam logic [1:0] REG_EXTENT_Z  = 2'd2;

	// shared divider: 64-bit signed dividend over 48-bit positive divisor
	localparam int DVD_W = 64;
	localparam int DVS_W = 48;

	typedef struct packed {
		logic                    go;
		logic signed [DVD_W-1:0] dividend;
		logic        [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [DVD_W-1:0] quot;
		logic        [DVS_W-1:0] rem;
	} div_rsp_t;

endpackage

### rtl/grid_terrain_height_query.sv
// Top level of the grid terrain height query block.
// Depends on gthq_pkg, gthq_divider and gthq_ram.
//
// A load, an unused op code or a point off the grid passes from the start beat through
// S_DONE into the done register. A query or raise maps the point through two divisions
// and reads three vertices; a query then finishes with a third division. Each division
// holds the one shared bit-serial divider, whose done flag is registered, and that
// divider sets the pace. Busy stays high from the start beat until the done cycle, so
// the next start is taken only once the block is idle again. Each result is shown for
// one cycle under done and cannot be stalled.
module grid_terrain_height_query (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [12:0]        vertex_index,
	input  logic [15:0]        point_x,
	input  logic [15:0]        point_z,
	input  logic signed [15:0] amount,
	output logic               done,
	output logic signed [15:0] surface_height,
	output logic               outside,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import gthq_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DIVX  = 4'd1;
	localparam logic [3:0] S_DIVZ  = 4'd2;
	localparam logic [3:0] S_TRI   = 4'd3;
	localparam logic [3:0] S_RD    = 4'd4;
	localparam logic [3:0] S_RAISE = 4'd5;
	localparam logic [3:0] S_MUL   = 4'd6;
	localparam logic [3:0] S_SUM   = 4'd7;
	localparam logic [3:0] S_DIVH  = 4'd8;
	localparam logic [3:0] S_WAIT  = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;
	localparam logic [3:0] S_DIVGO = 4'd11;

	logic [6:0]  divs_q;
	logic [15:0] ext_x_q, ext_z_q;

	logic [3:0]  state_q;
	logic [1:0]  op_q;
	logic [15:0] pz_q;
	logic signed [15:0] amt_q;
	logic [6:0]  d_q;
	logic [15:0] ex_q, ez_q;
	logic [5:0]  gx_q, gz_q;
	logic [16:0] rx_q, rz_q;
	logic        upper_q;
	logic [VIDX_W-1:0] v_q [3];
	logic signed [15:0] h_q [3];
	logic [1:0]  k_q;
	logic [1:0]  rk_q;
	logic signed [48:0] t1_s1, t2_s1;
	logic signed [63:0] num_q;
	logic signed [15:0] res_q;
	logic        out_q;
	logic        done_q;

	div_req_t dreq;
	div_rsp_t drsp;

	logic        ram_we;
	logic [VIDX_W-1:0] ram_addr;
	logic signed [15:0] ram_wd, ram_rd;

	gthq_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	gthq_ram u_ram (.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd),
		.rdata(ram_rd));

	logic        accept;
	logic [6:0]  d_eff;
	logic [15:0] ex_eff, ez_eff;
	logic [5:0]  cell_c;
	logic [16:0] rem_c;
	logic [15:0] ext_c;
	logic [12:0] row;
	logic        up_c;
	logic signed [17:0] dh1, dh2;
	logic signed [16:0] hsum;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign d_eff  = (divs_q == 7'd0) ? 7'd1
		: ((divs_q > 7'(MAX_DIVISIONS)) ? 7'(MAX_DIVISIONS) : divs_q);
	assign ex_eff = (ext_x_q == 16'd0) ? 16'd1 : ext_x_q;
	assign ez_eff = (ext_z_q == 16'd0) ? 16'd1 : ext_z_q;

	// clamp the far edge into the last cell
	assign ext_c = (state_q == S_DIVX) ? ex_q : ez_q;
	always_comb begin
		if (drsp.quot >= 64'(d_q)) begin
			cell_c = 6'(d_q - 7'd1);
			rem_c  = {1'b0, ext_c};
		end else begin
			cell_c = drsp.quot[5:0];
			rem_c  = drsp.rem[16:0];
		end
	end

	assign row  = 13'(gz_q) * 13'(d_q + 7'd1) + 13'(gx_q);
	assign up_c = (34'(rx_q) * 34'(ez_q) + 34'(rz_q) * 34'(ex_q)) >= 34'(ex_q) * 34'(ez_q);

	assign dh1 = 18'(h_q[1]) - 18'(h_q[0]);
	assign dh2 = 18'(h_q[2]) - 18'(h_q[0]);
	// raise writes back the heights captured during the reads plus the amount, saturated
	assign hsum = 17'(amt_q) + 17'(h_q[rk_q]);

	always_comb begin
		dreq.go       = 1'b0;
		dreq.dividend = '0;
		dreq.divisor  = '0;
		if (accept && (op == OP_QUERY || op == OP_RAISE)
			&& point_x <= ex_eff && point_z <= ez_eff) begin
			dreq.go       = 1'b1;
			dreq.dividend = 64'(point_x) * 64'(d_eff);
			dreq.divisor  = 48'(ex_eff);
		end else if (state_q == S_DIVX && drsp.done) begin
			dreq.go       = 1'b1;
			dreq.dividend = 64'(pz_q) * 64'(d_q);
			dreq.divisor  = 48'(ez_q);
		end else if (state_q == S_DIVGO) begin
			dreq.go       = 1'b1;
			dreq.dividend = 64'(2) * num_q + 64'(32'(ex_q) * 32'(ez_q));
			dreq.divisor  = 48'(33'(2) * 33'(32'(ex_q) * 32'(ez_q)));
		end
	end

	always_comb begin
		ram_we   = 1'b0;
		ram_addr = (k_q == 2'd3) ? v_q[2] : v_q[k_q];
		ram_wd   = amount;
		if (accept && op == OP_LOAD) begin
			ram_addr = vertex_index[VIDX_W-1:0];
			ram_we   = (vertex_index < 13'(VERTEX_COUNT));
		end else if (state_q == S_RAISE) begin
			ram_addr = v_q[rk_q];
			ram_we   = 1'b1;
			ram_wd   = (hsum > 17'sd32767) ? 16'sh7fff
				: ((hsum < -17'sd32768) ? -16'sh8000 : hsum[15:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divs_q  <= 7'd64;
			ext_x_q <= 16'd16384;
			ext_z_q <= 16'd16384;
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_DIVISIONS: divs_q  <= cfg_data[6:0];
					REG_EXTENT_X:  ext_x_q <= cfg_data;
					REG_EXTENT_Z:  ext_z_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= dreq.go ? S_DIVX : S_DONE;
					end
				end
				S_DIVX: if (drsp.done) state_q <= S_DIVZ;
				S_DIVZ: if (drsp.done) state_q <= S_TRI;
				S_TRI:  state_q <= S_RD;
				S_RD: begin
					if (k_q == 2'd3) begin
						state_q <= (op_q == OP_QUERY) ? S_MUL : S_RAISE;
					end
				end
				S_RAISE: if (rk_q == 2'd2) state_q <= S_DONE;
				S_MUL:  state_q <= S_SUM;
				S_SUM:  state_q <= S_DIVGO;
				S_DIVGO: state_q <= S_DIVH;
				S_DIVH: if (drsp.done) state_q <= S_WAIT;
				S_WAIT: state_q <= S_DONE;
				S_DONE: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			pz_q  <= point_z;
			amt_q <= amount;
			d_q   <= d_eff;
			ex_q  <= ex_eff;
			ez_q  <= ez_eff;
			res_q <= '0;
			out_q <= (op == OP_QUERY || op == OP_RAISE)
				&& (point_x > ex_eff || point_z > ez_eff);
		end
		case (state_q)
			S_DIVX: if (drsp.done) begin
				gx_q <= cell_c;
				rx_q <= rem_c;
			end
			S_DIVZ: if (drsp.done) begin
				gz_q <= cell_c;
				rz_q <= rem_c;
			end
			S_TRI: begin
				upper_q <= up_c;
				k_q     <= 2'd0;
				if (up_c) begin
					v_q[0] <= VIDX_W'(row + 13'(d_q) + 13'd2);
					v_q[1] <= VIDX_W'(row + 13'(d_q) + 13'd1);
					v_q[2] <= VIDX_W'(row + 13'd1);
				end else begin
					v_q[0] <= VIDX_W'(row);
					v_q[1] <= VIDX_W'(row + 13'd1);
					v_q[2] <= VIDX_W'(row + 13'(d_q) + 13'd1);
				end
			end
			S_RD: begin
				// read data is registered in the RAM and lags the address
				if (k_q != 2'd0) h_q[k_q - 2'd1] <= ram_rd;
				if (k_q != 2'd3) k_q <= k_q + 2'd1;
				rk_q <= 2'd0;
			end
			S_RAISE: begin
				rk_q <= rk_q + 2'd1;
			end
			S_MUL: begin
				t1_s1 <= 49'(upper_q ? (17'(ex_q) - rx_q) : rx_q) * 49'(dh1);
				t2_s1 <= 49'(upper_q ? (17'(ez_q) - rz_q) : rz_q) * 49'(dh2);
			end
			S_SUM: begin
				num_q <= 64'(t1_s1) * 64'(ez_q) + 64'(t2_s1) * 64'(ex_q);
			end
			S_WAIT: begin
				res_q <= (64'(h_q[0]) + drsp.quot > 64'sd32767) ? 16'sh7fff
					: ((64'(h_q[0]) + drsp.quot < -64'sd32768) ? -16'sh8000
					: 16'(64'(h_q[0]) + drsp.quot));
			end
			default: ;
		endcase
	end

	assign done           = done_q;
	assign surface_height = res_q;
	assign outside        = out_q;

endmodule

### rtl/gthq_divider.sv
// Shared iterative floor divider, one quotient bit per cycle.
// Depends on gthq_pkg for operand widths and the request/response structs.
module gthq_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  gthq_pkg::div_req_t req,
	output gthq_pkg::div_rsp_t rsp
);
	import gthq_pkg::*;

	logic             busy_q;
	logic [6:0]       cnt_q;
	logic [DVD_W-1:0] mag_q;
	logic [DVS_W:0]   rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic             neg_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   shifted;
	logic [DVD_W-1:0] qpos;
	logic             rem_nz;

	assign shifted = {rem_q[DVS_W-1:0], mag_q[DVD_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign rem_nz  = (rem_q != '0);
	assign qpos    = mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			neg_q <= req.dividend[DVD_W-1];
			mag_q <= req.dividend[DVD_W-1] ? DVD_W'(-req.dividend) : req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// restoring step: shift one dividend bit in, subtract if it fits
			if (!trial[DVS_W]) begin
				rem_q <= trial;
				mag_q <= {mag_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				mag_q <= {mag_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	// floor toward minus infinity for negative dividends
	always_comb begin
		rsp.done = done_q;
		if (neg_q && rem_nz) begin
			rsp.quot = DVD_W'(-$signed(qpos)) - DVD_W'(1);
			rsp.rem  = dvs_q - rem_q[DVS_W-1:0];
		end else begin
			rsp.quot = neg_q ? DVD_W'(-$signed(qpos)) : $signed(qpos);
			rsp.rem  = rem_q[DVS_W-1:0];
		end
	end

endmodule

### rtl/gthq_ram.sv
// Vertex height store, one port, registered read.
// Depends on gthq_pkg for depth and index width.
module gthq_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [gthq_pkg::VIDX_W-1:0] addr,
	input  logic signed [15:0]         wdata,
	output logic signed [15:0]         rdata
);
	import gthq_pkg::*;

	logic signed [15:0] mem [VERTEX_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### dv/gthq_checker.sv
// Checker for the grid terrain height query block: predicts and compares each result.
// Watches the command, result and register ports beside the block; depends on gthq_pkg.
`timescale 1ns / 1ps
module gthq_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         op,
	input  logic [12:0]        vertex_index,
	input  logic [15:0]        point_x,
	input  logic [15:0]        point_z,
	input  logic signed [15:0] amount,
	input  logic               done,
	input  logic signed [15:0] surface_height,
	input  logic               outside,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 fails,
	output int                 pending
);
	import gthq_pkg::*;

	typedef struct {
		logic signed [15:0] height;
		logic               off_grid;
	} terrain_result_t;

	terrain_result_t    height_q[$];
	logic signed [15:0] grid_heights [VERTEX_COUNT];
	logic [6:0]         divs;
	logic [15:0]        ext_x;
	logic [15:0]        ext_z;

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return v[15:0];
	endfunction

	function automatic void map_axis(input longint p, input longint ext, input longint d,
			output longint cell_idx, output longint rem);
		cell_idx = (p * d) / ext;
		rem      = (p * d) % ext;
		if (cell_idx >= d) begin
			cell_idx = d - 1;
			rem      = ext;
		end
	endfunction

	// Update the height store and return the one result caused by this beat.
	function automatic terrain_result_t terrain_step(input logic [1:0] o,
			input logic [12:0] vi, input logic [15:0] px, input logic [15:0] pz,
			input logic signed [15:0] am);
		terrain_result_t r;
		longint d, ex, ez, gx, gz, rx, rz, row, h0, h1, h2, wx, wz, num, den, q, n2, d2;
		longint v [3];
		bit upper;
		r.height   = '0;
		r.off_grid = 1'b0;
		d  = (divs == 0) ? 1 : (divs > MAX_DIVISIONS) ? MAX_DIVISIONS : longint'(divs);
		ex = (ext_x == 0) ? 1 : longint'(ext_x);
		ez = (ext_z == 0) ? 1 : longint'(ext_z);
		case (o)
			OP_LOAD: begin
				if (vi < VERTEX_COUNT)
					grid_heights[vi] = am;
			end
			OP_QUERY, OP_RAISE: begin
				if (longint'(px) > ex || longint'(pz) > ez) begin
					r.off_grid = 1'b1;
				end else begin
					map_axis(longint'(px), ex, d, gx, rx);
					map_axis(longint'(pz), ez, d, gz, rz);
					upper = (rx * ez + rz * ex) >= ex * ez;
					row = gz * (d + 1) + gx;
					if (upper) begin
						v[0] = row + d + 2;
						v[1] = row + d + 1;
						v[2] = row + 1;
					end else begin
						v[0] = row;
						v[1] = row + 1;
						v[2] = row + d + 1;
					end
					if (o == OP_QUERY) begin
						h0 = longint'(grid_heights[v[0]]);
						h1 = longint'(grid_heights[v[1]]);
						h2 = longint'(grid_heights[v[2]]);
						wx = upper ? ex - rx : rx;
						wz = upper ? ez - rz : rz;
						num = wx * (h1 - h0) * ez + wz * (h2 - h0) * ex;
						den = ex * ez;
						// round half up: floor((2*num + den) / (2*den))
						n2 = 2 * num + den;
						d2 = 2 * den;
						q = n2 / d2;
						if ((n2 % d2) != 0 && n2 < 0)
							q = q - 1;
						r.height = clamp16(h0 + q);
					end else begin
						for (int k = 0; k < 3; k++)
							grid_heights[v[k]] = clamp16(longint'(grid_heights[v[k]])
								+ longint'(am));
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		terrain_result_t exp_r;
		if (!arst_n) begin
			height_q.delete();
			fails   = 0;
			pending = 0;
			divs    = 7'd64;
			ext_x   = 16'd16384;
			ext_z   = 16'd16384;
			for (int i = 0; i < VERTEX_COUNT; i++)
				grid_heights[i] = '0;
		end else begin
			// compare first so a beat accepted on this edge never meets its own result
			if (done) begin
				if (height_q.size() == 0) begin
					$error("result with no beat outstanding: surface_height %0d outside %0b",
						surface_height, outside);
					fails++;
				end else begin
					exp_r = height_q.pop_front();
					if (surface_height !== exp_r.height) begin
						$error("surface_height expected %0d actual %0d",
							exp_r.height, surface_height);
						fails++;
					end
					if (outside !== exp_r.off_grid) begin
						$error("outside expected %0b actual %0b", exp_r.off_grid, outside);
						fails++;
					end
				end
			end
			if (start && !busy)
				height_q.push_back(terrain_step(op, vertex_index, point_x, point_z, amount));
			if (cfg_we) begin
				case (cfg_index)
					REG_DIVISIONS: divs  = cfg_data[6:0];
					REG_EXTENT_X:  ext_x = cfg_data;
					REG_EXTENT_Z:  ext_z = cfg_data;
					default: ;
				endcase
			end
			pending = height_q.size();
		end
	end

endmodule

### dv/tb_grid_terrain_height_query.sv
// Testbench top for the grid terrain height query block: clock, reset, commands, verdict.
// Depends on gthq_pkg, grid_terrain_height_query and gthq_checker.
`timescale 1ns / 1ps
module tb_grid_terrain_height_query;
	import gthq_pkg::*;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 280;
	localparam int FILL_N = 200;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         op;
	logic [12:0]        vertex_index;
	logic [15:0]        point_x;
	logic [15:0]        point_z;
	logic signed [15:0] amount;
	logic               done;
	logic signed [15:0] surface_height;
	logic               outside;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;
	int                 fails;
	int                 pending;
	int                 stall_cycles;
	logic [15:0]        cur_ext_x;
	logic [15:0]        cur_ext_z;
	logic [15:0]        cur_lim_x;
	logic [15:0]        cur_lim_z;

	grid_terrain_height_query dut (.*);
	gthq_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Hold start high until the block takes the beat; leave it high for a following beat.
	task automatic send_beat(input logic [1:0] o, input logic [12:0] vi,
			input logic [15:0] px, input logic [15:0] pz, input logic [15:0] am);
		bit taken;
		start        <= 1'b1;
		op           <= o;
		vertex_index <= vi;
		point_x      <= px;
		point_z      <= pz;
		amount       <= am;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 17)) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// Largest in-grid coordinate whose cells only touch the filled low vertices.
	function automatic logic [15:0] coord_limit(input logic [15:0] ext, input int d);
		int r;
		if ((d + 1) * (d + 1) <= FILL_N)
			return ext;
		r = (FILL_N - 1) / (d + 2) - 1;
		return 16'((int'(ext) * r) / d);
	endfunction

	task automatic configure(input logic [15:0] dv, input logic [15:0] ex,
			input logic [15:0] ez);
		int d;
		drain();
		write_reg(REG_DIVISIONS, dv);
		write_reg(REG_EXTENT_X, ex);
		write_reg(REG_EXTENT_Z, ez);
		cfg_we    <= 1'b0;
		cur_ext_x  = (ex == 0) ? 16'd1 : ex;
		cur_ext_z  = (ez == 0) ? 16'd1 : ez;
		d = (dv[6:0] == 7'd0) ? 1
			: (int'(dv[6:0]) > MAX_DIVISIONS) ? MAX_DIVISIONS : int'(dv[6:0]);
		cur_lim_x  = coord_limit(cur_ext_x, d);
		cur_lim_z  = coord_limit(cur_ext_z, d);
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_coord(input logic [15:0] ext, input logic [15:0] lim);
		int sel;
		logic [15:0] v;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			return lim;
		if (sel < 18 && ext != 16'hFFFF)
			return 16'($urandom_range(int'(ext) + 1, 65535));
		if (sel < 22) begin
			v = 16'($urandom);
			if (v > lim && v <= ext)
				v = lim;
			return v;
		end
		return 16'($urandom_range(0, int'(lim)));
	endfunction

	task automatic random_beat();
		int sel;
		logic [15:0] am;
		sel = $urandom_range(0, 99);
		am  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023) - 512);
		if (sel < 45)
			send_beat(OP_QUERY, 13'($urandom), pick_coord(cur_ext_x, cur_lim_x),
				pick_coord(cur_ext_z, cur_lim_z), am);
		else if (sel < 70)
			send_beat(OP_RAISE, 13'($urandom), pick_coord(cur_ext_x, cur_lim_x),
				pick_coord(cur_ext_z, cur_lim_z), am);
		else if (sel < 95)
			send_beat(OP_LOAD, ($urandom_range(0, 19) == 0) ? 13'($urandom)
				: 13'($urandom_range(0, VERTEX_COUNT - 1)), 16'($urandom), 16'($urandom), am);
		else
			send_beat(OP_NOP, 13'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	initial begin
		logic [15:0] div_set [7];
		logic [15:0] ex_set  [7];
		logic [15:0] ez_set  [7];
		int per_phase;
		start        = 1'b0;
		op           = OP_LOAD;
		vertex_index = '0;
		point_x      = '0;
		point_z      = '0;
		amount       = '0;
		cfg_we       = 1'b0;
		cfg_index    = REG_DIVISIONS;
		cfg_data     = '0;
		cur_ext_x    = 16'd16384;
		cur_ext_z    = 16'd16384;
		cur_lim_x    = 16'd16384;
		cur_lim_z    = 16'd16384;
		arst_n       = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the low vertices and the far corner triangle; random points stay on
		// cells whose vertices are filled
		for (int i = 0; i < FILL_N; i++)
			send_beat(OP_LOAD, 13'(i), 16'($urandom), 16'($urandom), 16'($urandom));
		send_beat(OP_LOAD, 13'(MAX_DIVISIONS * (MAX_DIVISIONS + 1) - 1), '0, '0,
			16'($urandom));
		send_beat(OP_LOAD, 13'(VERTEX_COUNT - 2), '0, '0, 16'($urandom));
		send_beat(OP_LOAD, 13'(VERTEX_COUNT - 1), '0, '0, 16'($urandom));

		// corners, far edge, off grid, saturation, ignored indexes, unused op
		send_beat(OP_QUERY, '0, 16'd0, 16'd0, '0);
		send_beat(OP_QUERY, '0, 16'd16384, 16'd16384, '0);
		send_beat(OP_QUERY, '0, 16'd16384, 16'd0, '0);
		send_beat(OP_QUERY, '0, 16'd16385, 16'd0, '0);
		send_beat(OP_QUERY, '0, 16'd0, 16'hFFFF, '0);
		send_beat(OP_RAISE, '0, 16'hFFFF, 16'hFFFF, 16'sd100);
		send_beat(OP_QUERY, '0, 16'd128, 16'd128, '0);
		send_beat(OP_QUERY, '0, 16'd127, 16'd128, '0);
		send_beat(OP_LOAD, 13'd0, '0, '0, 16'sd32767);
		send_beat(OP_RAISE, '0, 16'd10, 16'd10, 16'sd32767);
		send_beat(OP_QUERY, '0, 16'd10, 16'd10, '0);
		send_beat(OP_RAISE, '0, 16'd10, 16'd10, -16'sd32768);
		send_beat(OP_RAISE, '0, 16'd10, 16'd10, -16'sd32768);
		send_beat(OP_QUERY, '0, 16'd200, 16'd30, '0);
		send_beat(OP_LOAD, 13'h1FFF, '0, '0, 16'sd5);
		send_beat(OP_LOAD, 13'(VERTEX_COUNT), '0, '0, 16'sd5);
		send_beat(OP_LOAD, 13'(VERTEX_COUNT - 1), '0, '0, -16'sd32768);
		send_beat(OP_QUERY, '0, 16'd16384, 16'd16384, '0);
		send_beat(OP_NOP, 13'h1FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_beat(OP_RAISE, '0, 16'd16383, 16'd16383, 16'sd1);

		div_set = '{16'd1, 16'd0, 16'd127, 16'd7, 16'd64, 16'd33, 16'd3};
		ex_set  = '{16'hFFFF, 16'd0, 16'd1, 16'd1000, 16'd16384, 16'd40000, 16'd77};
		ez_set  = '{16'd1, 16'hFFFF, 16'd0, 16'd999, 16'd256, 16'd12345, 16'd3};
		per_phase = RANDOM_ITEMS / 7;
		for (int p = 0; p < 7; p++) begin
			configure(div_set[p], ex_set[p], ez_set[p]);
			for (int n = 0; n < per_phase; n++) begin
				random_beat();
				if (p < 6 && $urandom_range(0, 5) == 0)
					idle_burst();
				if (n == per_phase / 2 && p == 2)
					drain();
			end
		end

		drain();
		repeat (300) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### grid_terrain_height_query.f
rtl/gthq_pkg.sv
rtl/gthq_divider.sv
rtl/gthq_ram.sv
rtl/grid_terrain_height_query.sv
dv/gthq_checker.sv
dv/tb_grid_terrain_height_query.sv
